### sv/i2r_pkg.sv
package i2r_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned LETTER_W = 8;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned ROWS     = 13;

    localparam logic [VALUE_W-1:0]  MAX_VALUE = 12'd3999;
    localparam logic [IDX_W-1:0]    LAST_ROW  = 4'(ROWS - 1);

    localparam logic [LETTER_W-1:0] CH_NONE = 8'h00;
    localparam logic [LETTER_W-1:0] CH_M    = 8'h4D;
    localparam logic [LETTER_W-1:0] CH_D    = 8'h44;
    localparam logic [LETTER_W-1:0] CH_C    = 8'h43;
    localparam logic [LETTER_W-1:0] CH_L    = 8'h4C;
    localparam logic [LETTER_W-1:0] CH_X    = 8'h58;
    localparam logic [LETTER_W-1:0] CH_V    = 8'h56;
    localparam logic [LETTER_W-1:0] CH_I    = 8'h49;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SECOND
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;         // take value, start at row 0
        logic emit_empty;   // zero value: single empty result
        logic emit_first;   // put first letter of current row
        logic emit_second;  // put second letter of current row
        logic subtract;     // rest -= weight of current row
        logic advance;      // move to next row
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_zero;
        logic in_ok;
        logic fits;         // rest >= weight
        logic two_letter;
        logic rem_zero;     // rest - weight == 0
    } t_dp_sts;

    function automatic logic [VALUE_W-1:0] row_weight(input logic [IDX_W-1:0] k);
        logic [VALUE_W-1:0] w;
        unique case (k)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    function automatic logic [LETTER_W-1:0] row_first(input logic [IDX_W-1:0] k);
        logic [LETTER_W-1:0] ch;
        unique case (k)
            4'd0:    ch = CH_M;
            4'd1:    ch = CH_C;
            4'd2:    ch = CH_D;
            4'd3:    ch = CH_C;
            4'd4:    ch = CH_C;
            4'd5:    ch = CH_X;
            4'd6:    ch = CH_L;
            4'd7:    ch = CH_X;
            4'd8:    ch = CH_X;
            4'd9:    ch = CH_I;
            4'd10:   ch = CH_V;
            default: ch = CH_I;
        endcase
        return ch;
    endfunction

    // CH_NONE marks a one-letter symbol
    function automatic logic [LETTER_W-1:0] row_second(input logic [IDX_W-1:0] k);
        logic [LETTER_W-1:0] ch;
        unique case (k)
            4'd1:    ch = CH_M;
            4'd3:    ch = CH_D;
            4'd5:    ch = CH_C;
            4'd7:    ch = CH_L;
            4'd9:    ch = CH_X;
            4'd11:   ch = CH_V;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

### sv/i2r_dp.sv
module i2r_dp
    import i2r_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [VALUE_W-1:0]  i_value,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic                o_strobe,
    output logic [LETTER_W-1:0] o_letter,
    output logic                o_last,
    output logic                o_empty_res
);

    logic [VALUE_W-1:0]  r_rest, n_rest;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_strobe, n_strobe;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_last, n_last;
    logic                r_empty, n_empty;

    logic [VALUE_W-1:0]  weight;
    logic [VALUE_W-1:0]  diff;
    logic [LETTER_W-1:0] second_ch;

    assign weight    = row_weight(r_idx);
    assign diff      = r_rest - weight;
    assign second_ch = row_second(r_idx);

    assign o_sts.in_zero    = (i_value == '0);
    assign o_sts.in_ok      = (i_value <= MAX_VALUE);
    assign o_sts.fits       = (r_rest >= weight);
    assign o_sts.two_letter = (second_ch != CH_NONE);
    assign o_sts.rem_zero   = (diff == '0);

    always_comb begin
        n_rest   = r_rest;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_letter = r_letter;
        n_last   = r_last;
        n_empty  = r_empty;
        if (i_cmd.load) begin
            n_rest = i_value;
            n_idx  = '0;
        end
        if (i_cmd.emit_empty) begin
            n_strobe = 1'b1;
            n_letter = CH_NONE;
            n_last   = 1'b1;
            n_empty  = 1'b1;
        end
        if (i_cmd.emit_first) begin
            n_strobe = 1'b1;
            n_letter = row_first(r_idx);
            n_last   = !o_sts.two_letter && o_sts.rem_zero;
            n_empty  = 1'b0;
        end
        if (i_cmd.emit_second) begin
            n_strobe = 1'b1;
            n_letter = second_ch;
            n_last   = o_sts.rem_zero;
            n_empty  = 1'b0;
        end
        if (i_cmd.subtract) begin
            n_rest = diff;
        end
        if (i_cmd.advance && r_idx != LAST_ROW) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_rest   <= n_rest;
        r_idx    <= n_idx;
        r_letter <= n_letter;
        r_last   <= n_last;
        r_empty  <= n_empty;
    end

    assign o_strobe    = r_strobe;
    assign o_letter    = r_letter;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

endmodule

### sv/i2r_ctrl.sv
module i2r_ctrl
    import i2r_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_sts.in_zero) begin
                        o_cmd.emit_empty = 1'b1;
                    end else if (i_sts.in_ok) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_sts.fits) begin
                    o_cmd.emit_first = 1'b1;
                    if (i_sts.two_letter) begin
                        n_state = ST_SECOND;
                    end else begin
                        o_cmd.subtract = 1'b1;
                        if (i_sts.rem_zero) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_SECOND: begin
                o_cmd.emit_second = 1'b1;
                o_cmd.subtract    = 1'b1;
                n_state = i_sts.rem_zero ? ST_IDLE : ST_RUN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### sv/integer_to_roman_encoder_top.sv
// Integer to Roman numeral encoder. A value (0..3999) is taken when i_start
// is high and o_busy is low; it comes out as ASCII letters, one per o_strobe
// pulse, with o_last on the final letter. Results cannot be held off: each is
// valid for exactly one cycle. Zero gives one result with o_empty_res set and
// letter 0; values above 3999 are taken and dropped without any result. The
// encoder walks the 13-row symbol table with one compare/subtract step per
// cycle: each cycle either emits a letter or moves to the next row, and zero
// never raises o_busy. The first letter is emitted once the value is loaded
// into the rest register and every row before it is skipped, and goes out
// through the output register; the empty result for zero appears in the
// cycle after the transfer.
module integer_to_roman_encoder_top
    import i2r_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_busy,
    output logic                o_strobe,
    output logic [LETTER_W-1:0] o_letter,
    output logic                o_last,
    output logic                o_empty_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    i2r_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    i2r_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_strobe    (o_strobe),
        .o_letter    (o_letter),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_empty_res |-> o_last && o_letter == CH_NONE)
        else $error("empty result malformed");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_value == '0 |=> o_strobe && o_empty_res && !o_busy)
        else $error("zero value did not give empty result");

    a_range_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_value > MAX_VALUE |=> !o_busy && !o_strobe)
        else $error("out of range value not dropped");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_strobe && o_last)
        else $error("busy dropped without final letter");

endmodule
